// ===== rtl/core/fire_effect_pixel_filter_unit_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef FIRE_EFFECT_PIXEL_FILTER_UNIT_ASSERT_SVH
`define FIRE_EFFECT_PIXEL_FILTER_UNIT_ASSERT_SVH

// Checked property, disabled while the active-low reset is asserted.
`define FFPF_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that is also evaluated during reset.
`define FFPF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ffpf_pkg.sv =====
package ffpf_pkg;

    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 200;

    localparam int WIN_DEPTH = FRAME_WIDTH + 1;
    localparam int WIN_PTR_W = $clog2(WIN_DEPTH);
    localparam int COL_CNT_W = $clog2(FRAME_WIDTH);
    localparam int ROW_CNT_W = $clog2(FRAME_HEIGHT);

    localparam int PIX_W    = 8;
    localparam int SUM_W    = 10;
    localparam int COLUMN_W = 9;
    localparam int ROW_W    = 8;
    localparam int VALUE_W  = 6;
    localparam int RAND_W   = 31;
    localparam int THRESH_W = 16;
    localparam int STEP_W   = 8;
    localparam int MASK_W   = 8;
    localparam int DRAW_W   = 16;

    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 24;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // Generator constants. Two steps fold into r2 = r * A^2 + (A*C + C).
    localparam logic [RAND_W-1:0] LCG_MUL = 31'd1103515245;
    localparam logic [RAND_W-1:0] LCG_ADD = 31'd12345;
    localparam logic [63:0] LCG_MUL_SQ_FULL  = 64'd1103515245 * 64'd1103515245;
    localparam logic [63:0] LCG_ADD_TWO_FULL = 64'd1103515245 * 64'd12345 + 64'd12345;
    localparam logic [RAND_W-1:0] LCG_MUL_SQ  = LCG_MUL_SQ_FULL[RAND_W-1:0];
    localparam logic [RAND_W-1:0] LCG_ADD_TWO = LCG_ADD_TWO_FULL[RAND_W-1:0];

    localparam logic [RAND_W-1:0]   SEED_RESET   = 31'd1;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd8192;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 8'd16;
    localparam logic [MASK_W-1:0]   MASK_RESET   = 8'd3;

    localparam logic [DRAW_W-1:0] DRAW_MODULUS = 16'hffff;
    localparam logic [PIX_W-1:0]  PIX_MAX      = 8'd255;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_SEED   = 2'd0;
    localparam logic [1:0] REG_THRESH = 2'd1;
    localparam logic [1:0] REG_STEP   = 2'd2;
    localparam logic [1:0] REG_MASK   = 2'd3;

    // One updated pixel on its way from the front to the back.
    typedef struct packed {
        logic [SUM_W-1:0]    sum;
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } push_t;

    typedef struct packed {
        logic                seed_load;
        logic [RAND_W-1:0]   seed;
        logic [THRESH_W-1:0] thresh;
        logic [STEP_W-1:0]   step;
        logic [MASK_W-1:0]   mask;
    } cfg_t;

endpackage

// ===== rtl/core/ffpf_front.sv =====
module ffpf_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ffpf_pkg::PIX_W-1:0] pixel_in,
    input  logic                       frame_start,
    output ffpf_pkg::push_t            push,
    input  logic                       fifo_full
);
    import ffpf_pkg::*;

    logic [PIX_W-1:0] win_mem [WIN_DEPTH];

    logic [WIN_PTR_W-1:0] ptr_reg, ptr_next;
    logic [COL_CNT_W-1:0] col_reg, col_next;
    logic [ROW_CNT_W-1:0] row_reg, row_next;
    logic                 st_valid_reg, st_valid_next;

    logic [PIX_W-1:0]    old_reg, p1_reg, p2_reg;
    logic [PIX_W-1:0]    st_pix_reg, st_p1_reg, st_p2_reg;
    logic [COLUMN_W-1:0] st_col_reg;
    logic [ROW_W-1:0]    st_row_reg;

    logic                 accept;
    logic                 upd;
    logic                 drain;
    logic [COL_CNT_W-1:0] c_cur;
    logic [ROW_CNT_W-1:0] r_cur;

    assign drain    = st_valid_reg && !fifo_full;
    assign s_tready = !st_valid_reg || !fifo_full;
    assign accept   = s_tvalid && s_tready;

    assign c_cur = frame_start ? '0 : col_reg;
    assign r_cur = frame_start ? '0 : row_reg;
    assign upd   = (r_cur != '0) && (c_cur >= COL_CNT_W'(2));

    always_comb begin
        ptr_next      = ptr_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        st_valid_next = drain ? 1'b0 : st_valid_reg;
        if (accept) begin
            st_valid_next = upd;
            ptr_next = (ptr_reg == WIN_PTR_W'(WIN_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
            if (c_cur == COL_CNT_W'(FRAME_WIDTH - 1)) begin
                col_next = '0;
                row_next = (r_cur == ROW_CNT_W'(FRAME_HEIGHT - 1)) ? '0 : r_cur + 1'b1;
            end else begin
                col_next = c_cur + 1'b1;
                row_next = r_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            st_valid_reg <= 1'b0;
        end else begin
            ptr_reg      <= ptr_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            st_valid_reg <= st_valid_next;
        end
    end

    // The oldest entry is read and replaced by the new pixel at the same edge.
    always_ff @(posedge aclk) begin
        if (accept) begin
            win_mem[ptr_reg] <= pixel_in;
            old_reg          <= win_mem[ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_reg     <= pixel_in;
            p2_reg     <= p1_reg;
            st_pix_reg <= pixel_in;
            st_p1_reg  <= p1_reg;
            st_p2_reg  <= p2_reg;
            st_col_reg <= COLUMN_W'(c_cur - 1'b1);
            st_row_reg <= ROW_W'(r_cur - 1'b1);
        end
    end

    always_comb begin
        push.valid       = drain;
        push.item.sum    = SUM_W'(old_reg) + SUM_W'(st_p2_reg)
                         + SUM_W'(st_p1_reg) + SUM_W'(st_pix_reg);
        push.item.column = st_col_reg;
        push.item.row    = st_row_reg;
    end

endmodule

// ===== rtl/core/ffpf_fifo.sv =====
module ffpf_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ffpf_pkg::push_t       push,
    output logic                  full,
    output logic                  pop_valid,
    output ffpf_pkg::item_t       pop_item,
    input  logic                  pop
);
    import ffpf_pkg::*;

    item_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_push, do_pop;

    assign full      = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign do_push   = push.valid && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule

// ===== rtl/core/ffpf_back.sv =====
module ffpf_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ffpf_pkg::cfg_t                  cfg,
    input  logic                            q_valid,
    input  ffpf_pkg::item_t                 q_item,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ffpf_pkg::OUT_DATA_W-1:0] m_tdata
);
    import ffpf_pkg::*;

    logic [RAND_W-1:0] rand_reg, rand_next;
    logic [RAND_W-1:0] r1, r2;
    logic              b1_valid_reg, b1_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_adv;

    logic [DRAW_W-1:0]   b1_draw_reg;
    logic [MASK_W-1:0]   b1_noise_reg;
    item_t               b1_item_reg;

    logic [COLUMN_W-1:0] out_col_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic [VALUE_W-1:0]  out_val_reg;

    logic [DRAW_W-1:0] draw_red;
    logic              decay;
    logic [SUM_W-1:0]  s_decayed;
    logic [SUM_W:0]    s_noisy;
    logic [PIX_W-1:0]  s_clamped;

    assign out_adv = !out_valid_reg || m_tready;
    assign q_pop   = q_valid && (!b1_valid_reg || out_adv);

    // Both generator steps come straight from the current state.
    assign r1 = rand_reg * LCG_MUL + LCG_ADD;
    assign r2 = rand_reg * LCG_MUL_SQ + LCG_ADD_TWO;

    always_comb begin
        rand_next = rand_reg;
        if (cfg.seed_load) begin
            rand_next = cfg.seed;
        end else if (q_pop) begin
            rand_next = r2;
        end
        b1_valid_next  = q_pop ? 1'b1 : (out_adv ? 1'b0 : b1_valid_reg);
        out_valid_next = out_adv ? b1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rand_reg      <= SEED_RESET;
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rand_reg      <= rand_next;
            b1_valid_reg  <= b1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            b1_draw_reg  <= r1[RAND_W-1 -: DRAW_W];
            b1_noise_reg <= r2[16 +: MASK_W];
            b1_item_reg  <= q_item;
        end
    end

    // Decay, noise and clamp on the registered draws.
    always_comb begin
        draw_red  = (b1_draw_reg == DRAW_MODULUS) ? '0 : b1_draw_reg;
        decay     = draw_red < cfg.thresh;
        s_decayed = b1_item_reg.sum;
        if (decay) begin
            s_decayed = (b1_item_reg.sum > SUM_W'(cfg.step))
                      ? b1_item_reg.sum - SUM_W'(cfg.step) : '0;
        end
        s_noisy   = (SUM_W + 1)'(s_decayed) + (SUM_W + 1)'(b1_noise_reg & cfg.mask);
        s_clamped = (s_noisy > (SUM_W + 1)'(PIX_MAX)) ? PIX_MAX : s_noisy[PIX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (out_adv && b1_valid_reg) begin
            out_col_reg <= b1_item_reg.column;
            out_row_reg <= b1_item_reg.row;
            out_val_reg <= s_clamped[PIX_W-1:2];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_val_reg, out_row_reg, out_col_reg};

endmodule

// ===== rtl/core/fire_effect_pixel_filter_unit.sv =====
// Throughput: one pixel per cycle except while a full queue blocks the front stage;
// the result channel stalls only via the 4-entry queue.
// The line window is a 321-entry memory read and written once per pixel at one port.
// Reset: aresetn is synchronous, active low; counters, queue and valids clear,
// the generator loads seed 1 and the registers take their reset values.
module fire_effect_pixel_filter_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input pixel stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ffpf_pkg::IN_DATA_W-1:0]  s_tdata,   // [7:0] pixel_in
    input  logic [ffpf_pkg::IN_USER_W-1:0]  s_tuser,   // [0] frame_start
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ffpf_pkg::OUT_DATA_W-1:0] m_tdata,   // [8:0] column, [16:9] row,
                                                       // [22:17] new_value, [23] zero
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ffpf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ffpf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ffpf_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import ffpf_pkg::*;

    // Configuration registers. A seed write also reloads the generator in
    // the back end, so it takes effect for the next updated pixel.
    logic [RAND_W-1:0]   seed_reg;
    logic [THRESH_W-1:0] thresh_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [MASK_W-1:0]   mask_reg;

    logic       wr_en;
    logic [1:0] reg_idx;
    cfg_t       cfg;

    push_t push;
    logic  fifo_full;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg   <= SEED_RESET;
            thresh_reg <= THRESH_RESET;
            step_reg   <= STEP_RESET;
            mask_reg   <= MASK_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SEED:   seed_reg   <= pwdata[RAND_W-1:0];
                REG_THRESH: thresh_reg <= pwdata[THRESH_W-1:0];
                REG_STEP:   step_reg   <= pwdata[STEP_W-1:0];
                REG_MASK:   mask_reg   <= pwdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SEED:   prdata = APB_DATA_W'(seed_reg);
            REG_THRESH: prdata = APB_DATA_W'(thresh_reg);
            REG_STEP:   prdata = APB_DATA_W'(step_reg);
            REG_MASK:   prdata = APB_DATA_W'(mask_reg);
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        cfg.seed_load = wr_en && (reg_idx == REG_SEED);
        cfg.seed      = pwdata[RAND_W-1:0];
        cfg.thresh    = thresh_reg;
        cfg.step      = step_reg;
        cfg.mask      = mask_reg;
    end

    // The front end tracks the raster position, keeps the line window and
    // forms the four-pixel sum for every pixel that gets updated.
    ffpf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .pixel_in    (s_tdata[PIX_W-1:0]),
        .frame_start (s_tuser[0]),
        .push        (push),
        .fifo_full   (fifo_full)
    );

    // A short queue decouples the pixel stream from result back-pressure.
    ffpf_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .full      (fifo_full),
        .pop_valid (q_valid),
        .pop_item  (q_item),
        .pop       (q_pop)
    );

    // The back end runs the generator, applies decay and noise, and clamps.
    ffpf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/core/ffpf_checker.sv =====
`include "fire_effect_pixel_filter_unit_assert.svh"

module ffpf_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ffpf_pkg::OUT_DATA_W-1:0] m_tdata
);
    import ffpf_pkg::*;

    // A stalled result keeps its valid and its contents.
    `FFPF_ASSERT_RST(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Reset clears the result valid.
    `FFPF_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // Only interior columns are ever updated.
    `FFPF_ASSERT_RST(a_col_range, aclk, aresetn, m_tvalid |-> m_tdata[8:0] != '0 && m_tdata[8:0] <= COLUMN_W'(FRAME_WIDTH - 2), "column out of range")

    // The bottom row is never updated.
    `FFPF_ASSERT_RST(a_row_range, aclk, aresetn, m_tvalid |-> m_tdata[16:9] <= ROW_W'(FRAME_HEIGHT - 2), "row out of range")

endmodule

bind fire_effect_pixel_filter_unit ffpf_checker u_ffpf_checker (.*);
